// ===== sv/fbbc_pkg.sv =====
package fbbc_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 17;
    localparam int unsigned LCG_W      = 16;
    localparam int unsigned RATE_W     = 17;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_LCG_SEED       = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE_TAG_ONE   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE_TAG_TWO   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE_TAG_THREE = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE_UNTAGGED  = 3'd4;

    localparam logic [LCG_W-1:0]  LCG_SEED_RESET      = 16'd1;
    localparam logic [RATE_W-1:0] RATE_TAGGED_RESET   = 17'd0;
    localparam logic [RATE_W-1:0] RATE_UNTAGGED_RESET = 17'd13108;

    localparam logic [LCG_W-1:0] LCG_MUL = 16'd2053;
    localparam logic [LCG_W-1:0] LCG_ADD = 16'd13849;

    // Line position within a four-line record.
    localparam logic [1:0] PHASE_HEADER    = 2'd0;
    localparam logic [1:0] PHASE_SEQUENCE  = 2'd1;
    localparam logic [1:0] PHASE_SEPARATOR = 2'd2;

    localparam logic [7:0] CHR_DOT   = 8'h2E;
    localparam logic [7:0] CHR_COLON = 8'h3A;
    localparam logic [7:0] CHR_ONE   = 8'h31;
    localparam logic [7:0] CHR_TWO   = 8'h32;
    localparam logic [7:0] CHR_THREE = 8'h33;
    localparam logic [7:0] CHR_UP_C  = 8'h43;
    localparam logic [7:0] CHR_LO_C  = 8'h63;
    localparam logic [7:0] CHR_UP_G  = 8'h47;
    localparam logic [7:0] CHR_LO_G  = 8'h67;
    localparam logic [7:0] CHR_UP_T  = 8'h54;
    localparam logic [7:0] CHR_UP_A  = 8'h41;

    typedef struct packed {
        logic       mate;
        logic [7:0] char_out;
        logic       line_end;
        logic       methylated;
    } fbbc_result_t;

endpackage

// ===== sv/fbbc_core.sv =====
module fbbc_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   accept,
    input  logic                                   mate,
    input  logic [7:0]                             char_in,
    input  logic                                   line_end,
    input  logic                                   cfg_we,
    input  logic [fbbc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [fbbc_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    output fbbc_pkg::fbbc_result_t                 result
);
    import fbbc_pkg::*;

    logic [LCG_W-1:0]  lcg_reg, lcg_next;
    logic [1:0]        phase_reg, phase_next;
    logic [7:0]        prev_one_reg, prev_one_next;
    logic [7:0]        prev_two_reg, prev_two_next;
    logic [2:0]        tag_reg, tag_next;
    logic              keep_reg, keep_next;
    logic [RATE_W-1:0] rate_one_reg, rate_two_reg, rate_three_reg, rate_untagged_reg;
    logic [RATE_W-1:0] threshold;
    logic [LCG_W-1:0]  lcg_prod;
    logic [LCG_W-1:0]  lcg_step;
    logic [7:0]        char_conv;

    always_comb
    begin
        if (tag_reg[2])
            threshold = rate_three_reg;
        else if (tag_reg[1])
            threshold = rate_two_reg;
        else if (tag_reg[0])
            threshold = rate_one_reg;
        else
            threshold = rate_untagged_reg;
    end

    // The product is kept to 16 bits, which is the modulo of the generator.
    assign lcg_prod = LCG_W'(lcg_reg * LCG_MUL);
    assign lcg_step = lcg_prod + LCG_ADD;

    always_comb
    begin
        char_conv = char_in;
        if (phase_reg == PHASE_SEQUENCE && !keep_reg)
        begin
            if (!mate && (char_in == CHR_UP_C || char_in == CHR_LO_C))
                char_conv = CHR_UP_T;
            if (mate && (char_in == CHR_UP_G || char_in == CHR_LO_G))
                char_conv = CHR_UP_A;
        end
    end

    always_comb
    begin
        lcg_next      = lcg_reg;
        phase_next    = phase_reg;
        prev_one_next = prev_one_reg;
        prev_two_next = prev_two_reg;
        tag_next      = tag_reg;
        keep_next     = keep_reg;

        if (accept)
        begin
            if (phase_reg == PHASE_HEADER && !mate && prev_two_reg == CHR_DOT
                && char_in == CHR_COLON)
            begin
                case (prev_one_reg)
                    CHR_ONE:   tag_next = tag_reg | 3'b001;
                    CHR_TWO:   tag_next = tag_reg | 3'b010;
                    CHR_THREE: tag_next = tag_reg | 3'b100;
                    default:   tag_next = tag_reg;
                endcase
            end

            if (line_end)
            begin
                prev_one_next = '0;
                prev_two_next = '0;
                if (mate)
                begin
                    // The second mate's header end closes the header pair.
                    if (phase_reg == PHASE_HEADER)
                    begin
                        lcg_next  = lcg_step;
                        keep_next = ({1'b0, lcg_step} < threshold);
                        tag_next  = '0;
                    end
                    phase_next = phase_reg + 2'd1;
                end
            end
            else
            begin
                prev_two_next = prev_one_reg;
                prev_one_next = char_in;
            end
        end

        if (cfg_we && cfg_addr == REG_LCG_SEED)
            lcg_next = cfg_wdata[LCG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcg_reg           <= LCG_SEED_RESET;
            phase_reg         <= PHASE_HEADER;
            prev_one_reg      <= '0;
            prev_two_reg      <= '0;
            tag_reg           <= '0;
            keep_reg          <= 1'b0;
            rate_one_reg      <= RATE_TAGGED_RESET;
            rate_two_reg      <= RATE_TAGGED_RESET;
            rate_three_reg    <= RATE_TAGGED_RESET;
            rate_untagged_reg <= RATE_UNTAGGED_RESET;
        end
        else
        begin
            lcg_reg      <= lcg_next;
            phase_reg    <= phase_next;
            prev_one_reg <= prev_one_next;
            prev_two_reg <= prev_two_next;
            tag_reg      <= tag_next;
            keep_reg     <= keep_next;
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    REG_RATE_TAG_ONE:   rate_one_reg      <= cfg_wdata;
                    REG_RATE_TAG_TWO:   rate_two_reg      <= cfg_wdata;
                    REG_RATE_TAG_THREE: rate_three_reg    <= cfg_wdata;
                    REG_RATE_UNTAGGED:  rate_untagged_reg <= cfg_wdata;
                    default:            ;
                endcase
            end
        end
    end

    always_comb
    begin
        result.mate       = mate;
        result.char_out   = char_conv;
        result.line_end   = line_end;
        result.methylated = keep_next;
    end

endmodule

// ===== sv/fbbc_skid.sv =====
module fbbc_skid (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  fbbc_pkg::fbbc_result_t in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output fbbc_pkg::fbbc_result_t out_data
);
    import fbbc_pkg::*;

    logic         out_valid_reg;
    logic         skid_valid_reg;
    fbbc_result_t out_data_reg;
    fbbc_result_t skid_data_reg;

    // The input side sees only a registered ready, so the two sides are decoupled.
    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
                out_valid_reg <= in_valid;
        end
        else if (in_valid && in_ready)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_ready || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_data_reg <= skid_data_reg;
            else
                out_data_reg <= in_data;
        end
        else if (in_valid && in_ready)
            skid_data_reg <= in_data;
    end

endmodule

// ===== sv/fastq_bisulfite_base_converter_top.sv =====
// Bisulfite base converter for an interleaved paired FASTQ byte stream.
// Slave stream: one byte per transaction; tdata carries the byte, tuser the
// mate (0 first, 1 second) and tlast marks the last byte of a line. For each
// line index the whole first-mate line is sent before the second-mate line.
// Master stream: one transaction per input byte; tdata[7:0] is the byte after
// optional conversion, tdata[8] the current methylation decision, tuser and
// tlast are copied from the input.
// The configuration port writes the generator seed (index 0, also loads the
// generator) and the four thresholds (indexes 1 to 4); writes are taken
// whenever cfg_we is high and must only be made while the stream is idle.
// Each accepted byte is registered at the output, via the skid register when
// the receiver stalls. Throughput is one byte per cycle while m_axis_tready
// is high; per-byte decode, substitution and generator step are combinational.
// Reset clears the line phase, tag flags and decision, loads the generator
// with 1 and restores the default thresholds. When the receiver stalls, one
// more byte is held in a skid register and then s_axis_tready drops until the
// output drains; nothing is lost or repeated.
module fastq_bisulfite_base_converter_top (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [7:0]                             s_axis_tdata,   // [7:0] char_in
    input  logic                                   s_axis_tuser,   // [0] mate
    input  logic                                   s_axis_tlast,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [15:0]                            m_axis_tdata,   // [7:0] char_out, [8] methylated
    output logic                                   m_axis_tuser,   // [0] mate_out
    output logic                                   m_axis_tlast,
    input  logic                                   cfg_we,
    input  logic [fbbc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [fbbc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
    import fbbc_pkg::*;

    logic         in_accept;
    fbbc_result_t core_result;
    fbbc_result_t out_result;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    fbbc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .mate      (s_axis_tuser),
        .char_in   (s_axis_tdata),
        .line_end  (s_axis_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .result    (core_result)
    );

    fbbc_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (core_result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    assign m_axis_tdata = {7'b0, out_result.methylated, out_result.char_out};
    assign m_axis_tuser = out_result.mate;
    assign m_axis_tlast = out_result.line_end;

endmodule

// ===== sv/fbbc_checker.sv =====
module fbbc_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   s_axis_tvalid,
    input logic                                   s_axis_tready,
    input logic [7:0]                             s_axis_tdata,
    input logic                                   s_axis_tuser,
    input logic                                   s_axis_tlast,
    input logic                                   m_axis_tvalid,
    input logic                                   m_axis_tready,
    input logic [15:0]                            m_axis_tdata,
    input logic                                   m_axis_tuser,
    input logic                                   m_axis_tlast,
    input logic                                   cfg_we,
    input logic [fbbc_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input logic [fbbc_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
    import fbbc_pkg::*;

    // Input backpressure only happens while a result is waiting at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with an empty output");

    // Ready drops only after the output was stalled in the previous cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_axis_tready) |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("ready dropped without an output stall");

    // The padding above the decision bit stays zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:9] == 7'b0)
        else $error("nonzero padding in output tdata");

    // A stalled output transaction holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled output transaction changed");

endmodule

bind fastq_bisulfite_base_converter_top fbbc_checker u_fbbc_checker (.*);
